[hdl/lsp_pkg.sv]
// Types, constants and the reset table of the lagged subtractive generator.
package lsp_pkg;

    localparam int unsigned DEPTH  = 17;
    localparam int unsigned IDX_W  = $clog2(DEPTH);
    localparam int unsigned WORD_W = 15;
    localparam int unsigned LO_W   = 8;
    localparam int unsigned HI_W   = WORD_W - LO_W;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0]  t_idx;

    localparam t_word MODULUS = t_word'(32767);
    localparam t_idx  SHORT_RESET = t_idx'(4);
    localparam t_idx  LONG_RESET  = t_idx'(16);
    localparam t_idx  LAST_IDX    = t_idx'(DEPTH - 1);

    // The multiplier 9069 split into its low and high bytes.
    localparam int unsigned MULTIPLIER = 9069;
    localparam int unsigned MUL_LO     = MULTIPLIER % 256;
    localparam int unsigned MUL_HI     = MULTIPLIER / 256;

    localparam t_word INIT_WORDS [DEPTH] = '{
        t_word'(30788), t_word'(23052), t_word'(2053),  t_word'(19346),
        t_word'(10646), t_word'(19427), t_word'(23975), t_word'(19049),
        t_word'(10949), t_word'(19693), t_word'(29746), t_word'(26748),
        t_word'(2796),  t_word'(23890), t_word'(29168), t_word'(31924),
        t_word'(16499)
    };

    // One table write from the reseed unit.
    typedef struct packed {
        logic  en;
        logic  last;
        t_idx  addr;
        t_word data;
    } t_seed_wr;

endpackage

[hdl/lsp_seed_if.sv]
// Input channel of the generator: one seed word per draw.
interface lsp_seed_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] seed;

    modport source (output valid, output seed, input ready);
    modport sink   (input valid, input seed, output ready);
endinterface

[hdl/lsp_sample_if.sv]
// Output channel of the generator: one drawn sample per word.
interface lsp_sample_if;
    logic        valid;
    logic        ready;
    logic [14:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

[hdl/lsp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module lsp_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 17
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/lsp_seed.sv]
// Reseed unit: folds the seed to an odd 15-bit start and steps the fill recurrence.
module lsp_seed (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_seed,
    output lsp_pkg::t_seed_wr   o_wr
);

    logic                          r_busy, n_busy;
    lsp_pkg::t_idx                 r_cnt, n_cnt;
    logic [lsp_pkg::LO_W-1:0]      r_lo, n_lo;
    logic [lsp_pkg::HI_W-1:0]      r_hi, n_hi;

    logic [31:0]                   mag;
    lsp_pkg::t_word                sat;
    lsp_pkg::t_word                odd;
    logic [15:0]                   prod;
    logic [15:0]                   hi_sum;
    logic [lsp_pkg::LO_W-1:0]      step_lo;
    logic [lsp_pkg::HI_W-1:0]      step_hi;
    logic                          last;

    // Magnitude of the seed; the most negative value comes out as 2^31.
    always_comb begin
        mag = i_seed[31] ? (~i_seed + 32'd1) : i_seed;
        sat = (mag > 32'(lsp_pkg::MODULUS)) ? lsp_pkg::MODULUS
                                             : mag[lsp_pkg::WORD_W-1:0];
        odd = sat[0] ? sat : (sat - lsp_pkg::t_word'(1));
    end

    // One step of the byte-split multiply-by-9069 recurrence.
    always_comb begin
        prod    = 16'(r_lo) * 16'(lsp_pkg::MUL_LO);
        hi_sum  = 16'(prod[15:8]) + 16'(r_lo) * 16'(lsp_pkg::MUL_HI)
                + 16'(r_hi) * 16'(lsp_pkg::MUL_LO);
        step_lo = prod[7:0];
        step_hi = hi_sum[lsp_pkg::HI_W-1:0];
        last    = (r_cnt == lsp_pkg::LAST_IDX);
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_lo   = r_lo;
        n_hi   = r_hi;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_lo   = odd[lsp_pkg::LO_W-1:0];
            n_hi   = odd[lsp_pkg::WORD_W-1:lsp_pkg::LO_W];
        end else if (r_busy) begin
            n_lo  = step_lo;
            n_hi  = step_hi;
            n_cnt = r_cnt + lsp_pkg::t_idx'(1);
            if (last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_lo <= n_lo;
        r_hi <= n_hi;
    end

    assign o_wr.en   = r_busy;
    assign o_wr.last = r_busy && last;
    assign o_wr.addr = r_cnt;
    assign o_wr.data = {step_hi, step_lo};

endmodule

[hdl/lagged_subtractive_prng.sv]
// Top level of the lag-17/5 subtractive generator with modulus 32767.
// A seed word of zero draws at once from the table; a nonzero seed word first has
// the table refilled by the reseed unit.
// Each draw reads the table RAM, subtracts and writes back; the write-back waits
// while an earlier sample is unclaimed, and no seed word is taken until it is done.
// Reset: synchronous, active low; indices go to 4 and 16 and the table reads its
// seventeen reset constants until each entry is first written.
module lagged_subtractive_prng (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lsp_seed_if.sink             i_in,
    lsp_sample_if.source         o_out
);

    // The sequencer is one-hot: idle, refilling, reading the table, updating.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SEED = 4'b0010,
        S_READ = 4'b0100,
        S_CALC = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    lsp_pkg::t_idx          r_si, n_si;
    lsp_pkg::t_idx          r_li, n_li;
    logic [lsp_pkg::DEPTH-1:0] r_valid;
    logic                   r_va, r_vb;
    logic                   r_out_vld, n_out_vld;
    lsp_pkg::t_word         r_sample, n_sample;

    logic                   in_fire;
    logic                   seed_start;
    logic                   calc_fire;
    lsp_pkg::t_seed_wr      seed_wr;

    logic                   ram_we;
    lsp_pkg::t_idx          ram_waddr;
    lsp_pkg::t_word         ram_wdata;
    lsp_pkg::t_word         rd_a, rd_b;
    lsp_pkg::t_word         word_a, word_b;
    logic [lsp_pkg::WORD_W:0] diff;
    lsp_pkg::t_word         k;

    // A word is taken only while the sequencer is idle; the output register
    // lets a finished sample wait without holding up the next seed word.
    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign seed_start = in_fire && (i_in.seed != '0);

    lsp_seed u_seed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (seed_start),
        .i_seed  (i_in.seed),
        .o_wr    (seed_wr)
    );

    // The update fires once the previous sample has gone or is going now.
    assign calc_fire = (r_state == S_CALC) && (!r_out_vld || o_out.ready);

    // Both RAM copies take every write, so each can be read at its own lag.
    always_comb begin
        if (seed_wr.en) begin
            ram_we    = 1'b1;
            ram_waddr = seed_wr.addr;
            ram_wdata = seed_wr.data;
        end else begin
            ram_we    = calc_fire;
            ram_waddr = r_li;
            ram_wdata = k;
        end
    end

    lsp_ram #(.WIDTH(lsp_pkg::WORD_W), .DEPTH(lsp_pkg::DEPTH)) u_ram_short (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_si),
        .o_rdata (rd_a)
    );

    lsp_ram #(.WIDTH(lsp_pkg::WORD_W), .DEPTH(lsp_pkg::DEPTH)) u_ram_long (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_li),
        .o_rdata (rd_b)
    );

    // The indices do not move between the read and the update, so they also
    // pick the reset constant for an entry that has never been written.
    always_comb begin
        word_a = r_va ? rd_a : lsp_pkg::INIT_WORDS[r_si];
        word_b = r_vb ? rd_b : lsp_pkg::INIT_WORDS[r_li];
        diff   = {1'b0, word_a} - {1'b0, word_b};
        // A borrow means the difference is negative: fold it back by the modulus.
        k      = diff[lsp_pkg::WORD_W] ? (diff[lsp_pkg::WORD_W-1:0] + lsp_pkg::MODULUS)
                                       : diff[lsp_pkg::WORD_W-1:0];
    end

    always_comb begin
        n_state   = r_state;
        n_si      = r_si;
        n_li      = r_li;
        n_out_vld = r_out_vld && !o_out.ready;
        n_sample  = r_sample;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = seed_start ? S_SEED : S_READ;
                end
            end
            S_SEED: begin
                if (seed_wr.last) begin
                    n_state = S_READ;
                    n_si    = lsp_pkg::SHORT_RESET;
                    n_li    = lsp_pkg::LONG_RESET;
                end
            end
            S_READ: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                if (calc_fire) begin
                    n_state   = S_IDLE;
                    n_out_vld = 1'b1;
                    n_sample  = k;
                    n_si      = (r_si == '0) ? lsp_pkg::LAST_IDX
                                             : (r_si - lsp_pkg::t_idx'(1));
                    n_li      = (r_li == '0) ? lsp_pkg::LAST_IDX
                                             : (r_li - lsp_pkg::t_idx'(1));
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_si      <= lsp_pkg::SHORT_RESET;
            r_li      <= lsp_pkg::LONG_RESET;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_si      <= n_si;
            r_li      <= n_li;
            r_out_vld <= n_out_vld;
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
        end
        // Valid flags are sampled alongside the RAM read data.
        r_va     <= r_valid[r_si];
        r_vb     <= r_valid[r_li];
        r_sample <= n_sample;
    end

    assign o_out.valid  = r_out_vld;
    assign o_out.sample = r_sample;

endmodule

[hdl/lsp_check.sv]
// Port-level checker for the generator, bound to the top level.
module lsp_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [14:0] i_sample
);

    logic [1:0] r_pending;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Words accepted whose samples have not yet been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sample))
        else $error("sample word dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("seed taken again while a draw was in progress");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 2'd2)
        else $error("more than two words outstanding");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == 2'd0 |-> !i_out_valid)
        else $error("sample shown without a seed word behind it");

endmodule

bind lagged_subtractive_prng lsp_check u_lsp_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_sample    (o_out.sample)
);
